// ===== design/sgs_pkg.sv =====
package sgs_pkg;

  // Function codes carried by each input transaction
  typedef logic [1:0] func_t;
  localparam func_t FUNC_TICK       = 2'd0;
  localparam func_t FUNC_TOGGLE_GATE = 2'd1;
  localparam func_t FUNC_TOGGLE_LOCK = 2'd2;
  localparam func_t FUNC_REGEN      = 2'd3;

  // Per-step lock encoding
  typedef logic [1:0] lock_t;
  localparam lock_t LOCK_NONE = 2'd0;
  localparam lock_t LOCK_ON   = 2'd1;
  localparam lock_t LOCK_OFF  = 2'd2;

  localparam int SPS_W = 24;
  localparam logic [SPS_W-1:0] SPS_RESET = 24'd5512;

  typedef struct packed {
    func_t       func;
    logic [3:0]  step_index;
    logic [15:0] random_bits;
  } item_t;

  typedef struct packed {
    logic        trigger;
    logic [3:0]  position;
    logic [15:0] gate_mask;
    logic [15:0] lock_on_mask;
    logic [15:0] lock_off_mask;
  } result_t;

endpackage

// ===== design/step_gate_sequencer.sv =====
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  in_func, in_step_index, in_random_bits
// out_      output     out_valid/out_stall out_trigger, out_position, out_gate_mask,
//                                          out_lock_on_mask, out_lock_off_mask
// cfg_      input      cfg_wr_en          cfg_wr_data (samples_per_step)
//
// After input acceptance the transaction sits in the input register and moves into
// the result register, where it is offered, once that register is empty or taken.
// One transaction per cycle sustained while the receiver does not stall;
// the step update is a single pass of bit logic on small registers.
// Reset (rst_n low, synchronous) clears count, position, gates and locks and
// loads samples_per_step with 5512. A stalled result holds in the output
// register while the input register still takes one more transaction.
module step_gate_sequencer #(
  parameter int STEPS      = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [sgs_pkg::SPS_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                in_func,
  input  logic [3:0]                in_step_index,
  input  logic [15:0]               in_random_bits,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_trigger,
  output logic [3:0]                out_position,
  output logic [15:0]               out_gate_mask,
  output logic [15:0]               out_lock_on_mask,
  output logic [15:0]               out_lock_off_mask
);
  import sgs_pkg::*;

  logic    hold_valid_r, hold_valid_nxt;
  item_t   hold_r;
  logic    out_valid_r, out_valid_nxt;
  result_t res_r;
  result_t res_nxt;
  logic    in_accept;
  logic    advance;

  // Advance the held transaction whenever the result register is empty or
  // its contents are being taken this cycle.
  assign advance   = hold_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = hold_valid_r && !advance;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    if (in_accept)    hold_valid_nxt = 1'b1;
    else if (advance) hold_valid_nxt = 1'b0;

    // Drop the result once taken, unless a fresh one replaces it
    out_valid_nxt = out_valid_r && out_stall;
    if (advance) out_valid_nxt = 1'b1;
  end

  // State and next-result logic; state commits as the transaction advances
  sgs_core #(
    .STEPS      (STEPS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item_fire   (advance),
    .item        (hold_r),
    .result      (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers: input captures on acceptance, result on advance; hold otherwise
  always_ff @(posedge clk) begin
    if (in_accept) begin
      hold_r.func        <= in_func;
      hold_r.step_index  <= in_step_index;
      hold_r.random_bits <= in_random_bits;
    end
    if (advance) res_r <= res_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_trigger       = res_r.trigger;
  assign out_position      = res_r.position;
  assign out_gate_mask     = res_r.gate_mask;
  assign out_lock_on_mask  = res_r.lock_on_mask;
  assign out_lock_off_mask = res_r.lock_off_mask;

endmodule

// ===== design/sgs_core.sv =====
module sgs_core #(
  parameter int STEPS      = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [sgs_pkg::SPS_W-1:0]   cfg_wr_data,
  input  logic                        item_fire,
  input  sgs_pkg::item_t              item,
  output sgs_pkg::result_t            result
);
  import sgs_pkg::*;

  localparam int POS_W = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int CMP_W = (COUNT_BITS + 1 > SPS_W) ? COUNT_BITS + 1 : SPS_W;

  logic [SPS_W-1:0]      sps_r;
  logic [COUNT_BITS-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [POS_W-1:0]      pos_r, pos_nxt;
  logic [STEPS-1:0]      gate_r, gate_nxt;
  lock_t [STEPS-1:0]     lock_r, lock_nxt;

  logic [COUNT_BITS:0]   cnt_inc;
  logic [SPS_W-1:0]      step_len;
  logic                  step_done;
  logic                  trig;
  logic [STEPS+15:0]     rnd_ext;
  logic [STEPS+15:0]     gate_ext, on_ext, off_ext;
  logic [POS_W+3:0]      pos_ext;

  always_comb begin
    cnt_inc   = {1'b0, tick_cnt_r} + {{COUNT_BITS{1'b0}}, 1'b1};
    step_len  = (sps_r == '0) ? {{(SPS_W-1){1'b0}}, 1'b1} : sps_r;
    step_done = CMP_W'(cnt_inc) >= CMP_W'(step_len);
    rnd_ext   = (STEPS+16)'(item.random_bits);

    tick_cnt_nxt = tick_cnt_r;
    pos_nxt      = pos_r;
    gate_nxt     = gate_r;
    lock_nxt     = lock_r;
    trig         = 1'b0;

    unique case (item.func)
      FUNC_TICK: begin
        if (step_done) begin
          tick_cnt_nxt = '0;
          pos_nxt      = (pos_r == POS_W'(STEPS-1)) ? '0 : pos_r + {{(POS_W-1){1'b0}}, 1'b1};
          trig         = gate_r[pos_nxt];
        end else begin
          tick_cnt_nxt = cnt_inc[COUNT_BITS-1:0];
        end
      end
      FUNC_TOGGLE_GATE: begin
        for (int i = 0; i < STEPS; i++) begin
          if (int'(item.step_index) == i) gate_nxt[i] = ~gate_r[i];
        end
      end
      FUNC_TOGGLE_LOCK: begin
        for (int i = 0; i < STEPS; i++) begin
          if (int'(item.step_index) == i) begin
            case (lock_r[i])
              LOCK_ON: begin
                lock_nxt[i] = LOCK_OFF;
                gate_nxt[i] = 1'b0;
              end
              LOCK_OFF: begin
                lock_nxt[i] = LOCK_NONE;
              end
              default: begin
                lock_nxt[i] = LOCK_ON;
                gate_nxt[i] = 1'b1;
              end
            endcase
          end
        end
      end
      FUNC_REGEN: begin
        for (int i = 0; i < STEPS; i++) begin
          if (lock_r[i] == LOCK_NONE) gate_nxt[i] = rnd_ext[i];
        end
      end
      default: begin
      end
    endcase

    // Report the state left behind by this transaction
    gate_ext = (STEPS+16)'(gate_nxt);
    on_ext   = '0;
    off_ext  = '0;
    for (int i = 0; i < STEPS; i++) begin
      on_ext[i]  = (lock_nxt[i] == LOCK_ON);
      off_ext[i] = (lock_nxt[i] == LOCK_OFF);
    end
    pos_ext = (POS_W+4)'(pos_nxt);

    result.trigger       = trig;
    result.position      = pos_ext[3:0];
    result.gate_mask     = gate_ext[15:0];
    result.lock_on_mask  = on_ext[15:0];
    result.lock_off_mask = off_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sps_r      <= SPS_RESET;
      tick_cnt_r <= '0;
      pos_r      <= '0;
      gate_r     <= '0;
      lock_r     <= {STEPS{LOCK_NONE}};
    end else begin
      if (cfg_wr_en) sps_r <= cfg_wr_data;
      if (item_fire) begin
        tick_cnt_r <= tick_cnt_nxt;
        pos_r      <= pos_nxt;
        gate_r     <= gate_nxt;
        lock_r     <= lock_nxt;
      end
    end
  end

endmodule

// ===== test/tb_step_gate_sequencer.sv =====
module tb_step_gate_sequencer;
  import sgs_pkg::*;

  // Cap on the run, in clock cycles, reckoned well above the slowest legal run
  localparam int CYCLE_LIMIT = 200000;
  // Length of the long receiver hold-off that fills the pipeline
  localparam int HOLD_CYCLES = 50;
  localparam int PHASE_ITEMS = 260;

  // Tracks the sequencer's count, position, gates and locks, and holds the
  // results still to come, oldest first.
  class sequencer_tracker;
    logic [SPS_W-1:0] step_len;
    logic [SPS_W-1:0] tick_count;
    logic [3:0]       position;
    logic [15:0]      gates;
    lock_t            locks [16];
    result_t          expected_steps [$];
    int               error_count;

    function new();
      step_len    = SPS_RESET;
      tick_count  = '0;
      position    = '0;
      gates       = '0;
      foreach (locks[i]) locks[i] = LOCK_NONE;
      error_count = 0;
    endfunction

    function void set_step_len(logic [SPS_W-1:0] value);
      step_len = value;
    endfunction

    // Apply one accepted transaction and queue the result it must produce
    function void accept_item(item_t it);
      logic [SPS_W:0]   next_count;
      logic [SPS_W-1:0] len;
      result_t          r;
      r = '0;
      case (it.func)
        FUNC_TICK: begin
          // a zero step length behaves as one tick per step
          len        = (step_len == '0) ? SPS_W'(1) : step_len;
          next_count = {1'b0, tick_count} + 1'b1;
          if (next_count >= {1'b0, len}) begin
            tick_count = '0;
            position   = position + 1'b1;
            r.trigger  = gates[position];
          end else begin
            tick_count = next_count[SPS_W-1:0];
          end
        end
        FUNC_TOGGLE_GATE: begin
          // flips even when the step is locked
          gates[it.step_index] = ~gates[it.step_index];
        end
        FUNC_TOGGLE_LOCK: begin
          case (locks[it.step_index])
            LOCK_ON: begin
              locks[it.step_index] = LOCK_OFF;
              gates[it.step_index] = 1'b0;
            end
            LOCK_OFF: locks[it.step_index] = LOCK_NONE;
            default: begin
              locks[it.step_index] = LOCK_ON;
              gates[it.step_index] = 1'b1;
            end
          endcase
        end
        FUNC_REGEN: begin
          for (int i = 0; i < 16; i++)
            if (locks[i] == LOCK_NONE) gates[i] = it.random_bits[i];
        end
      endcase
      r.position  = position;
      r.gate_mask = gates;
      for (int i = 0; i < 16; i++) begin
        r.lock_on_mask[i]  = (locks[i] == LOCK_ON);
        r.lock_off_mask[i] = (locks[i] == LOCK_OFF);
      end
      expected_steps.push_back(r);
    endfunction

    function void report_field(string name, logic [15:0] want, logic [15:0] got);
      error_count++;
      $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
    endfunction

    // Compare one delivered result against the oldest expectation
    function void check_step(result_t got);
      result_t want;
      if (expected_steps.size() == 0) begin
        error_count++;
        $display("%0t unexpected result %h with nothing pending", $time, got);
        return;
      end
      want = expected_steps.pop_front();
      if (got.trigger !== want.trigger)
        report_field("trigger", 16'(want.trigger), 16'(got.trigger));
      if (got.position !== want.position)
        report_field("position", 16'(want.position), 16'(got.position));
      if (got.gate_mask !== want.gate_mask)
        report_field("gate_mask", want.gate_mask, got.gate_mask);
      if (got.lock_on_mask !== want.lock_on_mask)
        report_field("lock_on_mask", want.lock_on_mask, got.lock_on_mask);
      if (got.lock_off_mask !== want.lock_off_mask)
        report_field("lock_off_mask", want.lock_off_mask, got.lock_off_mask);
    endfunction
  endclass

  // Initialise every block input to a known value from time zero
  logic              clk            = 1'b0;
  logic              rst_n          = 1'b0;
  logic              cfg_wr_en      = 1'b0;
  logic [SPS_W-1:0]  cfg_wr_data    = '0;
  logic              in_valid       = 1'b0;
  logic              in_stall;
  logic [1:0]        in_func        = '0;
  logic [3:0]        in_step_index  = '0;
  logic [15:0]       in_random_bits = '0;
  logic              out_valid;
  logic              out_stall      = 1'b0;
  logic              out_trigger;
  logic [3:0]        out_position;
  logic [15:0]       out_gate_mask;
  logic [15:0]       out_lock_on_mask;
  logic [15:0]       out_lock_off_mask;

  sequencer_tracker tracker = new();

  bit idling_on    = 1'b1;
  bit hold_request = 1'b0;
  int cycle_count  = 0;

  step_gate_sequencer u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_step_index     (in_step_index),
    .in_random_bits    (in_random_bits),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_trigger       (out_trigger),
    .out_position      (out_position),
    .out_gate_mask     (out_gate_mask),
    .out_lock_on_mask  (out_lock_on_mask),
    .out_lock_off_mask (out_lock_off_mask)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abandon the run if it hangs well beyond the slowest legal finish
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // Sample the result channel at the falling edge: the handshake and payload
  // are settled there and hold until the rising edge that takes the transaction.
  always @(negedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_step(result_t'({out_trigger, out_position, out_gate_mask,
                                    out_lock_on_mask, out_lock_off_mask}));
  end

  // Receiver: stall in short random bursts while idling is on, and hold off
  // for a long stretch whenever the stimulus asks, so the block backs up.
  initial begin : receiver
    int hold_left;
    int burst_left;
    hold_left  = 0;
    burst_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst_left > 0) begin
        burst_left--;
        out_stall <= 1'b1;
      end else if (idling_on && $urandom_range(0, 3) == 0) begin
        burst_left = $urandom_range(0, 2);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Write the step length; call only with nothing in flight, at a rising edge
  task automatic write_step_len(input logic [SPS_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    tracker.set_step_len(value);
  endtask

  // Offer one transaction, optionally after a short gap, and note it once taken.
  // Enter and leave at a rising edge.
  task automatic send_item(input func_t func, input logic [3:0] idx,
                           input logic [15:0] bits);
    item_t it;
    it.func        = func;
    it.step_index  = idx;
    it.random_bits = bits;
    if (idling_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= func;
    in_step_index  <= idx;
    in_random_bits <= bits;
    // the handshake seen at the falling edge decides the next rising edge
    @(negedge clk);
    while (in_stall !== 1'b0) @(negedge clk);
    tracker.accept_item(it);
    @(posedge clk);
  endtask

  // Mostly ticks, so that steps advance and triggers fire often
  task automatic send_random_item();
    int    pick;
    func_t func;
    pick = $urandom_range(0, 99);
    if (pick < 60)      func = FUNC_TICK;
    else if (pick < 75) func = FUNC_TOGGLE_GATE;
    else if (pick < 88) func = FUNC_TOGGLE_LOCK;
    else                func = FUNC_REGEN;
    send_item(func, 4'($urandom_range(0, 15)), 16'($urandom));
  endtask

  // Drop valid and wait until every expected result has been delivered
  task automatic drain();
    in_valid <= 1'b0;
    while (tracker.expected_steps.size() != 0) @(posedge clk);
  endtask

  task automatic run_phase(input logic [SPS_W-1:0] len, input bit with_idling,
                           input bit with_hold);
    write_step_len(len);
    idling_on = with_idling;
    for (int k = 0; k < PHASE_ITEMS; k++) begin
      if (with_hold && k == PHASE_ITEMS / 4) hold_request = 1'b1;
      send_random_item();
    end
    drain();
  endtask

  initial begin
    // hold reset, then release it once and for all
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // At the reset step length ticks only count up, never advance
    repeat (3) send_item(FUNC_TICK, 4'd0, 16'h0000);
    drain();

    // Directed: every function, the extreme step indices and bit patterns,
    // toggles on locked steps and a regenerate that must spare locked steps
    write_step_len(24'd1);
    send_item(FUNC_REGEN,       4'd0,  16'hFFFF);
    send_item(FUNC_TICK,        4'd0,  16'h0000);
    send_item(FUNC_TOGGLE_LOCK, 4'd0,  16'h0000);
    send_item(FUNC_TOGGLE_LOCK, 4'd15, 16'hFFFF);
    send_item(FUNC_TOGGLE_LOCK, 4'd15, 16'h0000);
    send_item(FUNC_TOGGLE_GATE, 4'd15, 16'h0000);
    send_item(FUNC_TOGGLE_GATE, 4'd0,  16'hFFFF);
    send_item(FUNC_REGEN,       4'd0,  16'h0000);
    send_item(FUNC_REGEN,       4'd9,  16'h5555);
    send_item(FUNC_TOGGLE_GATE, 4'd7,  16'h0000);
    repeat (4) send_item(FUNC_TICK, 4'd15, 16'hFFFF);
    send_item(FUNC_TOGGLE_LOCK, 4'd15, 16'h0000);
    send_item(FUNC_TOGGLE_LOCK, 4'd0,  16'h0000);
    send_item(FUNC_TOGGLE_LOCK, 4'd0,  16'h0000);
    send_item(FUNC_REGEN,       4'd0,  16'hAAAA);
    drain();

    // Random phases over several step lengths, the extremes among them;
    // one phase runs without idling, and the last part has none at all
    run_phase(24'd0,                       1'b1, 1'b1);
    run_phase(24'd2,                       1'b1, 1'b0);
    run_phase(24'hFFFFFF,                  1'b1, 1'b0);
    run_phase(24'd3,                       1'b0, 1'b0);
    run_phase(SPS_W'($urandom_range(4, 9)), 1'b1, 1'b1);
    run_phase(SPS_W'($urandom_range(1, 5)), 1'b1, 1'b0);
    run_phase(24'd1,                       1'b0, 1'b0);

    // let any stray result show itself before judging
    repeat (8) @(posedge clk);
    if (tracker.error_count == 0 && tracker.expected_steps.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
